@@ design/bounded_ordered_key_value_store_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered key/value store
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_KEY_VALUE_STORE_TOP_MACROS_SVH
`define BOUNDED_ORDERED_KEY_VALUE_STORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define BOKV_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bokv check failed");
// next-cycle implication, disabled in reset
`define BOKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bokv check failed");
`else
`define BOKV_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BOKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/bokv_pkg.sv @@
// ----------------------------------------------------------------------------
// bokv_pkg
// Shared request codes, datapath commands and status for the ordered store.
// ----------------------------------------------------------------------------
`default_nettype none
package bokv_pkg;

    localparam int DEPTH_DEFAULT      = 32;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int MAX_RESULTS        = 32;
    localparam int LIMIT_BITS         = 6;
    localparam int COUNT_BITS         = 6;

    localparam logic [3:0] REQ_LOOKUP      = 4'd0;
    localparam logic [3:0] REQ_INSERT_HEAD = 4'd1;
    localparam logic [3:0] REQ_INSERT_TAIL = 4'd2;
    localparam logic [3:0] REQ_REPLACE     = 4'd3;
    localparam logic [3:0] REQ_DELETE      = 4'd4;
    localparam logic [3:0] REQ_POP_TAIL    = 4'd5;
    localparam logic [3:0] REQ_PEEK_HEAD   = 4'd6;
    localparam logic [3:0] REQ_PEEK_TAIL   = 4'd7;
    localparam logic [3:0] REQ_CLEAR       = 4'd8;
    localparam logic [3:0] REQ_DUMP        = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_PICK_HIT,
        OP_PICK_TAIL,
        OP_PICK_HEAD,
        OP_PICK_FREE,
        OP_READ,
        OP_UNLINK,
        OP_LINK_A,
        OP_LINK_B,
        OP_WRVAL,
        OP_CLEAR,
        OP_DUMP_STEP
    } t_dp_op;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_HIT,
        SRC_RD
    } t_emit_src;

    typedef struct packed {
        logic      en;
        logic      status;
        t_emit_src src;
        logic      last_dump;
    } t_emit;

    typedef struct packed {
        t_dp_op op;
        logic   at_tail;
        t_emit  emit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic empty;
        logic evict;
        logic free_ok;
        logic dump_last;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ design/bokv_datapath.sv @@
// ----------------------------------------------------------------------------
// bokv_datapath
// Slot memories, link pointers, scan compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bokv_datapath #(
    parameter int DEPTH      = bokv_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS   = bokv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = bokv_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bokv_pkg::LIMIT_BITS-1:0]    i_cfg_wdata,
    input  wire logic [31:0]                        i_key,
    input  wire logic [31:0]                        i_value,
    input  wire bokv_pkg::t_dp_cmd                  i_cmd,
    output bokv_pkg::t_dp_stat                      o_stat,
    output logic                                    o_result_valid,
    output logic                                    o_status,
    output logic [31:0]                             o_out_key,
    output logic [31:0]                             o_out_value,
    output logic [bokv_pkg::COUNT_BITS-1:0]         o_entry_count,
    output logic                                    o_last_result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int EW = ((SW > bokv_pkg::LIMIT_BITS) ? SW : bokv_pkg::LIMIT_BITS) + 1;
    localparam logic [SW-1:0] NullSlot = SW'(DEPTH);
    localparam logic [SW-1:0] LastIdx  = SW'(DEPTH - 1);

    // slot memories
    logic [KEY_BITS-1:0]   r_key_mem  [DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem  [DEPTH];
    logic [SW-1:0]         r_next_mem [DEPTH];
    logic [SW-1:0]         r_prev_mem [DEPTH];

    // control state
    logic [SW-1:0]                   r_head;
    logic [SW-1:0]                   r_tail;
    logic [SW-1:0]                   r_count;
    logic [DEPTH-1:0]                r_valid;
    logic [bokv_pkg::LIMIT_BITS-1:0] r_limit;
    logic [SW-1:0]                   r_idx;
    logic                            r_cmp_live;
    logic                            r_hit;
    logic                            r_free_found;
    logic                            r_res_valid;
    logic [SW-1:0]                   r_dcnt;

    // payload
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [SW-1:0]         r_hit_slot;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic [SW-1:0]         r_free_slot;
    logic [SW-1:0]         r_slot;
    logic [SW-1:0]         r_cmp_idx;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [SW-1:0]         r_rd_next;
    logic [SW-1:0]         r_rd_prev;
    logic                  r_status;
    logic [31:0]           r_out_key;
    logic [31:0]           r_out_value;
    logic                  r_last;

    logic            scan_issue;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            cmp_valid;
    logic            cmp_match;
    logic [EW-1:0]   limit_eff;
    logic [EW-1:0]   dump_next;
    logic            dump_last;
    logic            val_we;
    logic [IW-1:0]   val_waddr;
    logic            next_we;
    logic [IW-1:0]   next_waddr;
    logic [SW-1:0]   next_wdata;
    logic            prev_we;
    logic [IW-1:0]   prev_waddr;
    logic [SW-1:0]   prev_wdata;

    // read address: scan index or working slot
    assign scan_issue = (i_cmd.op == bokv_pkg::OP_SCAN) && (r_idx != NullSlot);
    assign rd_en      = scan_issue || (i_cmd.op == bokv_pkg::OP_READ);
    assign rd_addr    = scan_issue ? r_idx[IW-1:0] : r_slot[IW-1:0];

    assign cmp_valid = r_valid[r_cmp_idx[IW-1:0]];
    assign cmp_match = cmp_valid && (r_rd_key == r_key);

    // effective limit: zero or above depth means full depth
    assign limit_eff = ((r_limit == '0) || (EW'(r_limit) > EW'(DEPTH))) ?
                       EW'(DEPTH) : EW'(r_limit);

    // dump ends at chain end, at count or at the result cap
    assign dump_next = EW'(r_dcnt) + EW'(1);
    assign dump_last = (r_rd_next == NullSlot) || (dump_next >= EW'(r_count)) ||
                       (dump_next >= EW'(bokv_pkg::MAX_RESULTS));

    always_comb begin
        o_stat.scan_done = r_cmp_live && (r_cmp_idx == LastIdx);
        o_stat.hit       = r_hit;
        o_stat.empty     = (r_head == NullSlot);
        o_stat.evict     = (r_count != '0) && (EW'(r_count) >= limit_eff);
        o_stat.free_ok   = r_free_found;
        o_stat.dump_last = dump_last;
    end

    // memory write ports
    always_comb begin
        val_we     = 1'b0;
        val_waddr  = r_slot[IW-1:0];
        next_we    = 1'b0;
        next_waddr = r_slot[IW-1:0];
        next_wdata = NullSlot;
        prev_we    = 1'b0;
        prev_waddr = r_slot[IW-1:0];
        prev_wdata = NullSlot;
        case (i_cmd.op)
            bokv_pkg::OP_WRVAL: begin
                val_we    = 1'b1;
                val_waddr = r_hit_slot[IW-1:0];
            end
            bokv_pkg::OP_UNLINK: begin
                next_we    = (r_rd_prev != NullSlot);
                next_waddr = r_rd_prev[IW-1:0];
                next_wdata = r_rd_next;
                prev_we    = (r_rd_next != NullSlot);
                prev_waddr = r_rd_next[IW-1:0];
                prev_wdata = r_rd_prev;
            end
            bokv_pkg::OP_LINK_A: begin
                next_we    = (r_head != NullSlot) && i_cmd.at_tail;
                next_waddr = r_tail[IW-1:0];
                next_wdata = r_slot;
                prev_we    = (r_head != NullSlot) && !i_cmd.at_tail;
                prev_waddr = r_head[IW-1:0];
                prev_wdata = r_slot;
            end
            bokv_pkg::OP_LINK_B: begin
                val_we     = 1'b1;
                next_we    = 1'b1;
                next_wdata = ((r_head == NullSlot) || i_cmd.at_tail) ? NullSlot : r_head;
                prev_we    = 1'b1;
                prev_wdata = ((r_head == NullSlot) || !i_cmd.at_tail) ? NullSlot : r_tail;
            end
            default: begin
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bokv_pkg::OP_LINK_B) begin
            r_key_mem[r_slot[IW-1:0]] <= r_key;
        end
        if (val_we) begin
            r_val_mem[val_waddr] <= r_val;
        end
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we) begin
            r_prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en) begin
            r_rd_key  <= r_key_mem[rd_addr];
            r_rd_val  <= r_val_mem[rd_addr];
            r_rd_next <= r_next_mem[rd_addr];
            r_rd_prev <= r_prev_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= NullSlot;
            r_tail       <= NullSlot;
            r_count      <= '0;
            r_valid      <= '0;
            r_limit      <= '0;
            r_idx        <= '0;
            r_cmp_live   <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_res_valid  <= 1'b0;
            r_dcnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_cmp_live  <= scan_issue;
            r_res_valid <= i_cmd.emit.en;
            // record first key match and first free slot
            if (r_cmp_live) begin
                if (cmp_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!cmp_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            case (i_cmd.op)
                bokv_pkg::OP_LOAD: begin
                    r_idx        <= '0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                end
                bokv_pkg::OP_SCAN: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                bokv_pkg::OP_PICK_HEAD: begin
                    r_dcnt <= '0;
                end
                bokv_pkg::OP_DUMP_STEP: begin
                    r_dcnt <= r_dcnt + SW'(1);
                end
                bokv_pkg::OP_UNLINK: begin
                    if (r_head == r_slot) begin
                        r_head <= r_rd_next;
                    end
                    if (r_tail == r_slot) begin
                        r_tail <= r_rd_prev;
                    end
                    r_valid[r_slot[IW-1:0]] <= 1'b0;
                    if (r_count != '0) begin
                        r_count <= r_count - SW'(1);
                    end
                    r_free_found <= 1'b1;
                end
                bokv_pkg::OP_LINK_B: begin
                    r_valid[r_slot[IW-1:0]] <= 1'b1;
                    r_count <= r_count + SW'(1);
                    if (r_head == NullSlot) begin
                        r_head <= r_slot;
                        r_tail <= r_slot;
                    end else if (i_cmd.at_tail) begin
                        r_tail <= r_slot;
                    end else begin
                        r_head <= r_slot;
                    end
                end
                bokv_pkg::OP_CLEAR: begin
                    r_valid <= '0;
                    r_head  <= NullSlot;
                    r_tail  <= NullSlot;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (i_cmd.op == bokv_pkg::OP_LOAD) begin
            r_key <= KEY_BITS'(i_key);
            r_val <= VALUE_BITS'(i_value);
        end
        if (r_cmp_live) begin
            if (cmp_match && !r_hit) begin
                r_hit_slot <= r_cmp_idx;
                r_hit_val  <= r_rd_val;
            end
            if (!cmp_valid && !r_free_found) begin
                r_free_slot <= r_cmp_idx;
            end
        end
        // a freed slot competes with the lowest free slot seen by the scan
        if (i_cmd.op == bokv_pkg::OP_UNLINK) begin
            if (!r_free_found || (r_slot < r_free_slot)) begin
                r_free_slot <= r_slot;
            end
        end
        case (i_cmd.op)
            bokv_pkg::OP_PICK_HIT:  r_slot <= r_hit_slot;
            bokv_pkg::OP_PICK_TAIL: r_slot <= r_tail;
            bokv_pkg::OP_PICK_HEAD: r_slot <= r_head;
            bokv_pkg::OP_PICK_FREE: r_slot <= r_free_slot;
            bokv_pkg::OP_DUMP_STEP: r_slot <= r_rd_next;
            default: begin
            end
        endcase
        // result word
        if (i_cmd.emit.en) begin
            r_status <= i_cmd.emit.status;
            r_last   <= i_cmd.emit.last_dump ? dump_last : 1'b1;
            case (i_cmd.emit.src)
                bokv_pkg::SRC_HIT: begin
                    r_out_key   <= 32'(r_key);
                    r_out_value <= 32'(r_hit_val);
                end
                bokv_pkg::SRC_RD: begin
                    r_out_key   <= 32'(r_rd_key);
                    r_out_value <= 32'(r_rd_val);
                end
                default: begin
                    r_out_key   <= '0;
                    r_out_value <= '0;
                end
            endcase
        end
    end

    logic [bokv_pkg::COUNT_BITS-1:0] r_entry_count;
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit.en) begin
            r_entry_count <= bokv_pkg::COUNT_BITS'(r_count);
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_out_key      = r_out_key;
    assign o_out_value    = r_out_value;
    assign o_entry_count  = r_entry_count;
    assign o_last_result  = r_last;

endmodule
`default_nettype wire

@@ design/bokv_ctrl.sv @@
// ----------------------------------------------------------------------------
// bokv_ctrl
// Request sequencer: scan, relink and emit steps for each request.
// ----------------------------------------------------------------------------
`default_nettype none
module bokv_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [3:0]         i_req_type,
    input  wire bokv_pkg::t_dp_stat i_stat,
    output bokv_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DEL_READ,
        S_DEL_UNLINK,
        S_DEL_EMIT,
        S_POP_PICK,
        S_PEEK_PICK,
        S_PEEK_READ,
        S_PEEK_EMIT,
        S_EV_READ,
        S_EV_UNLINK,
        S_PICK_FREE,
        S_MV_READ,
        S_MV_UNLINK,
        S_LINK_A,
        S_LINK_B,
        S_DONE,
        S_CLEAR,
        S_ERR,
        S_DUMP_PICK,
        S_DUMP_READ,
        S_DUMP_EMIT
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_req;
    logic [3:0] n_req;

    // emit helper values
    localparam bokv_pkg::t_emit EmitMiss = '{en: 1'b1, status: 1'b1,
                                             src: bokv_pkg::SRC_ZERO, last_dump: 1'b0};
    localparam bokv_pkg::t_emit EmitDone = '{en: 1'b1, status: 1'b0,
                                             src: bokv_pkg::SRC_ZERO, last_dump: 1'b0};
    localparam bokv_pkg::t_emit EmitRd   = '{en: 1'b1, status: 1'b0,
                                             src: bokv_pkg::SRC_RD, last_dump: 1'b0};

    always_comb begin
        n_state         = r_state;
        n_req           = r_req;
        o_cmd.op        = bokv_pkg::OP_NONE;
        o_cmd.at_tail   = (r_req == bokv_pkg::REQ_INSERT_TAIL);
        o_cmd.emit      = '{en: 1'b0, status: 1'b0, src: bokv_pkg::SRC_ZERO, last_dump: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = bokv_pkg::OP_LOAD;
                    n_req    = i_req_type;
                    unique case (i_req_type) inside
                        bokv_pkg::REQ_LOOKUP, bokv_pkg::REQ_INSERT_HEAD,
                        bokv_pkg::REQ_INSERT_TAIL, bokv_pkg::REQ_REPLACE,
                        bokv_pkg::REQ_DELETE:                   n_state = S_SCAN;
                        bokv_pkg::REQ_POP_TAIL:                 n_state = S_POP_PICK;
                        bokv_pkg::REQ_PEEK_HEAD,
                        bokv_pkg::REQ_PEEK_TAIL:                n_state = S_PEEK_PICK;
                        bokv_pkg::REQ_CLEAR:                    n_state = S_CLEAR;
                        bokv_pkg::REQ_DUMP:                     n_state = S_DUMP_PICK;
                        default:                                n_state = S_ERR;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.op = bokv_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (r_req) inside
                    bokv_pkg::REQ_LOOKUP: begin
                        n_state = S_IDLE;
                        if (i_stat.hit) begin
                            o_cmd.emit = '{en: 1'b1, status: 1'b0,
                                           src: bokv_pkg::SRC_HIT, last_dump: 1'b0};
                        end else begin
                            o_cmd.emit = EmitMiss;
                        end
                    end
                    bokv_pkg::REQ_DELETE: begin
                        if (i_stat.hit) begin
                            o_cmd.op = bokv_pkg::OP_PICK_HIT;
                            n_state  = S_DEL_READ;
                        end else begin
                            o_cmd.emit = EmitMiss;
                            n_state    = S_IDLE;
                        end
                    end
                    bokv_pkg::REQ_REPLACE: begin
                        if (i_stat.hit) begin
                            o_cmd.op = bokv_pkg::OP_PICK_HIT;
                            n_state  = S_MV_READ;
                        end else if (i_stat.evict) begin
                            o_cmd.op = bokv_pkg::OP_PICK_TAIL;
                            n_state  = S_EV_READ;
                        end else begin
                            n_state = S_PICK_FREE;
                        end
                    end
                    default: begin
                        // insert at head or tail
                        if (i_stat.hit) begin
                            o_cmd.op   = bokv_pkg::OP_WRVAL;
                            o_cmd.emit = EmitDone;
                            n_state    = S_IDLE;
                        end else if (i_stat.evict) begin
                            o_cmd.op = bokv_pkg::OP_PICK_TAIL;
                            n_state  = S_EV_READ;
                        end else begin
                            n_state = S_PICK_FREE;
                        end
                    end
                endcase
            end
            S_DEL_READ: begin
                o_cmd.op = bokv_pkg::OP_READ;
                n_state  = S_DEL_UNLINK;
            end
            S_DEL_UNLINK: begin
                o_cmd.op = bokv_pkg::OP_UNLINK;
                n_state  = S_DEL_EMIT;
            end
            S_DEL_EMIT: begin
                o_cmd.emit = EmitRd;
                n_state    = S_IDLE;
            end
            S_POP_PICK: begin
                if (i_stat.empty) begin
                    o_cmd.emit = EmitMiss;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = bokv_pkg::OP_PICK_TAIL;
                    n_state  = S_DEL_READ;
                end
            end
            S_PEEK_PICK: begin
                if (i_stat.empty) begin
                    o_cmd.emit = EmitMiss;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = (r_req == bokv_pkg::REQ_PEEK_HEAD) ?
                               bokv_pkg::OP_PICK_HEAD : bokv_pkg::OP_PICK_TAIL;
                    n_state  = S_PEEK_READ;
                end
            end
            S_PEEK_READ: begin
                o_cmd.op = bokv_pkg::OP_READ;
                n_state  = S_PEEK_EMIT;
            end
            S_PEEK_EMIT: begin
                o_cmd.emit = EmitRd;
                n_state    = S_IDLE;
            end
            S_EV_READ: begin
                o_cmd.op = bokv_pkg::OP_READ;
                n_state  = S_EV_UNLINK;
            end
            S_EV_UNLINK: begin
                o_cmd.op = bokv_pkg::OP_UNLINK;
                n_state  = S_PICK_FREE;
            end
            S_PICK_FREE: begin
                if (i_stat.free_ok) begin
                    o_cmd.op = bokv_pkg::OP_PICK_FREE;
                    n_state  = S_LINK_A;
                end else begin
                    o_cmd.emit = EmitDone;
                    n_state    = S_IDLE;
                end
            end
            S_MV_READ: begin
                o_cmd.op = bokv_pkg::OP_READ;
                n_state  = S_MV_UNLINK;
            end
            S_MV_UNLINK: begin
                o_cmd.op = bokv_pkg::OP_UNLINK;
                n_state  = S_LINK_A;
            end
            S_LINK_A: begin
                o_cmd.op = bokv_pkg::OP_LINK_A;
                n_state  = S_LINK_B;
            end
            S_LINK_B: begin
                o_cmd.op = bokv_pkg::OP_LINK_B;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = EmitDone;
                n_state    = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.op = bokv_pkg::OP_CLEAR;
                n_state  = S_DONE;
            end
            S_ERR: begin
                o_cmd.emit = EmitMiss;
                n_state    = S_IDLE;
            end
            S_DUMP_PICK: begin
                if (i_stat.empty) begin
                    o_cmd.emit = EmitMiss;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = bokv_pkg::OP_PICK_HEAD;
                    n_state  = S_DUMP_READ;
                end
            end
            S_DUMP_READ: begin
                o_cmd.op = bokv_pkg::OP_READ;
                n_state  = S_DUMP_EMIT;
            end
            S_DUMP_EMIT: begin
                o_cmd.op   = bokv_pkg::OP_DUMP_STEP;
                o_cmd.emit = '{en: 1'b1, status: 1'b0,
                               src: bokv_pkg::SRC_RD, last_dump: 1'b1};
                n_state    = i_stat.dump_last ? S_IDLE : S_DUMP_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and the request code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= bokv_pkg::REQ_LOOKUP;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ design/bounded_ordered_key_value_store_top.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_key_value_store_top
// Ordered key/value store of DEPTH slots with tail eviction.
//
// Channel   Direction  Handshake                    Word
// request   in         i_start high, o_busy low     i_req_type, i_key, i_value
// result    out        o_result_valid, one cycle    o_status .. o_last_result
// config    in         i_cfg_we                     i_cfg_wdata (entry limit)
//
// Lookup, insert, replace and delete scan all DEPTH slots one per cycle
// through the key memory read port, then relink and emit.
// Pop, peek and dump answer an empty store with a miss, as does an unknown code;
// dump walks the entries from the head. Each result shows in the cycle after its emit step.
// Reset is synchronous; no clearing pass, the store is ready after reset.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_ordered_key_value_store_top_macros.svh"
module bounded_ordered_key_value_store_top #(
    parameter int DEPTH      = bokv_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS   = bokv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = bokv_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bokv_pkg::LIMIT_BITS-1:0] i_cfg_wdata,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [3:0]                      i_req_type,
    input  wire logic [31:0]                     i_key,
    input  wire logic [31:0]                     i_value,
    output logic                                 o_result_valid,
    output logic                                 o_status,
    output logic [31:0]                          o_out_key,
    output logic [31:0]                          o_out_value,
    output logic [bokv_pkg::COUNT_BITS-1:0]      o_entry_count,
    output logic                                 o_last_result
);

    bokv_pkg::t_dp_cmd  dp_cmd;
    bokv_pkg::t_dp_stat dp_stat;

    // sequencer
    bokv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (o_busy)
    );

    // storage and result path
    bokv_datapath #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_value    (o_out_value),
        .o_entry_count  (o_entry_count),
        .o_last_result  (o_last_result)
    );

    // an accepted word always starts a sequence
    `BOKV_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // a miss or error is a single zero-payload result
    `BOKV_ASSERT_SAME(a_miss_single, i_clk, i_rst_n, o_result_valid && o_status, o_last_result && (o_out_key == 32'd0))
    // a dump result that is not last keeps the block busy
    `BOKV_ASSERT_SAME(a_dump_busy, i_clk, i_rst_n, o_result_valid && !o_last_result, o_busy)

endmodule
`default_nettype wire
